// ===== rtl/core/pif_pkg.sv =====
// ----------------------------------------------------------------------------
// Palette inversion fader package
// Shared widths, constants, item types and the sequencer state type.
// ----------------------------------------------------------------------------
package pif_pkg;

  localparam int NUM_ENTRIES  = 9;
  localparam int FRAC_BITS    = 8;
  localparam int FRAC_SCALE   = 1 << FRAC_BITS;
  localparam int CH_BITS      = 5;
  localparam int CH_MAX       = 31;
  localparam int NUM_CH       = 3;
  localparam int CH_W         = $clog2(NUM_CH);
  localparam int COLOR_W      = NUM_CH * CH_BITS;
  localparam int ENT_W        = 4;
  localparam int IDX_W        = $clog2(NUM_ENTRIES);
  localparam int FRAMES_W     = 8;
  localparam int FRAMES_RESET = 32;
  localparam int LEVEL_W      = CH_BITS + FRAC_BITS;
  localparam int LEVEL_MAX    = CH_MAX * FRAC_SCALE;
  localparam int STEP_W       = LEVEL_W + 1;
  localparam int SUM_W        = LEVEL_W + 2;
  localparam int DIV_STEPS    = LEVEL_W;
  localparam int CNT_W        = $clog2(DIV_STEPS);

  localparam logic [COLOR_W-1:0] COLOR_MASK = '1;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  typedef struct packed {
    req_t               req_type;
    logic [ENT_W-1:0]   entry_index;
    logic [COLOR_W-1:0] base_color;
    logic               night;
    logic               invert_over;
  } in_item_t;

  typedef struct packed {
    logic [ENT_W-1:0]   out_index;
    logic [COLOR_W-1:0] color;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIV_STORE,
    ST_CALC,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/core/palette_inversion_fader.sv =====
// ----------------------------------------------------------------------------
// Palette inversion fader
// Fades a nine-entry BGR555 palette between base colours and their inverses.
// ----------------------------------------------------------------------------
// A load item with an entry number in range keeps the block busy while the
// step of each of the three channels comes from one shared restoring divider
// that yields one quotient bit a cycle, plus a store state for each step. A
// tick item visits each entry in turn, as one shared adder and saturator
// moves one channel level a cycle and an emit state places the entry's item
// in the output register; with invert_over set only the emit state runs per
// entry. Stalls on the output hold the run in the emit state.
// The output register lets the next input item be taken while the last result
// of a tick still waits.
module palette_inversion_fader (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pif_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pif_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pif_pkg::FRAMES_W-1:0]   cfg_data
);

  pif_pkg::state_t state_r, state_nxt;

  logic [pif_pkg::FRAMES_W-1:0] frames_r;
  logic [pif_pkg::COLOR_W-1:0]  base_r  [pif_pkg::NUM_ENTRIES];
  logic [pif_pkg::LEVEL_W-1:0]  level_r [pif_pkg::NUM_ENTRIES][pif_pkg::NUM_CH];
  logic [pif_pkg::STEP_W-1:0]   step_r  [pif_pkg::NUM_ENTRIES][pif_pkg::NUM_CH];

  logic [pif_pkg::IDX_W-1:0]    ent_r;
  logic [pif_pkg::IDX_W-1:0]    lidx_r;
  logic [pif_pkg::CH_W-1:0]     ch_r;
  logic [pif_pkg::CNT_W-1:0]    cnt_r;
  logic                         night_r;
  logic                         snap_r;
  logic [pif_pkg::COLOR_W-1:0]  color_r;
  logic [pif_pkg::COLOR_W-1:0]  col_r;
  logic [pif_pkg::FRAMES_W-1:0] rem_r;
  logic [pif_pkg::LEVEL_W-1:0]  quo_r;
  logic                         out_valid_r;
  pif_pkg::out_item_t           out_data_r;

  logic                         in_acc;
  logic                         in_stall_c;
  logic                         emit_go;
  logic                         load_ok;
  logic                         div_last;
  logic                         ent_last;
  logic                         ch_last;
  logic [pif_pkg::FRAMES_W-1:0] frames_eff;
  logic [pif_pkg::FRAMES_W:0]   div_trial;
  logic                         div_ge;
  logic [pif_pkg::FRAMES_W-1:0] rem_next;
  logic [pif_pkg::CH_BITS-1:0]  cur_chan;
  logic [pif_pkg::STEP_W-1:0]   step_val;
  logic [pif_pkg::LEVEL_W-1:0]  lvl;
  logic [pif_pkg::STEP_W-1:0]   stp;
  logic [pif_pkg::SUM_W-1:0]    sum;
  logic [pif_pkg::LEVEL_W-1:0]  sat;
  logic [pif_pkg::COLOR_W-1:0]  emit_color;

  function automatic logic [pif_pkg::CH_BITS-1:0] chan_of(
    input logic [pif_pkg::COLOR_W-1:0] c,
    input logic [pif_pkg::CH_W-1:0]    ch
  );
    logic [pif_pkg::CH_BITS-1:0] v;
    case (ch)
      2'd0:    v = c[pif_pkg::CH_BITS-1:0];
      2'd1:    v = c[2*pif_pkg::CH_BITS-1:pif_pkg::CH_BITS];
      2'd2:    v = c[3*pif_pkg::CH_BITS-1:2*pif_pkg::CH_BITS];
      default: v = '0;
    endcase
    return v;
  endfunction

  // Magnitude of (inverse - channel) scaled to fixed point.
  function automatic logic [pif_pkg::LEVEL_W-1:0] num_of(
    input logic [pif_pkg::CH_BITS-1:0] c
  );
    logic [pif_pkg::CH_BITS:0] two_c;
    logic [pif_pkg::CH_BITS:0] mag;
    two_c = {c, 1'b0};
    if (c[pif_pkg::CH_BITS-1]) begin
      mag = two_c - (pif_pkg::CH_BITS+1)'(pif_pkg::CH_MAX);
    end else begin
      mag = (pif_pkg::CH_BITS+1)'(pif_pkg::CH_MAX) - two_c;
    end
    return {mag[pif_pkg::CH_BITS-1:0], pif_pkg::FRAC_BITS'(0)};
  endfunction

  assign in_acc     = in_valid && !in_stall_c;
  assign load_ok    = (in_data.entry_index >= pif_pkg::ENT_W'(1)) &&
                      (in_data.entry_index <= pif_pkg::ENT_W'(pif_pkg::NUM_ENTRIES));
  assign frames_eff = (frames_r == '0) ? pif_pkg::FRAMES_W'(1) : frames_r;
  assign div_trial  = {rem_r, quo_r[pif_pkg::LEVEL_W-1]};
  assign div_ge     = div_trial >= {1'b0, frames_eff};
  assign rem_next   = div_ge ? pif_pkg::FRAMES_W'(div_trial - {1'b0, frames_eff})
                             : div_trial[pif_pkg::FRAMES_W-1:0];
  assign div_last   = cnt_r == pif_pkg::CNT_W'(pif_pkg::DIV_STEPS - 1);
  assign ent_last   = ent_r == pif_pkg::IDX_W'(pif_pkg::NUM_ENTRIES - 1);
  assign ch_last    = ch_r == pif_pkg::CH_W'(pif_pkg::NUM_CH - 1);
  assign cur_chan   = chan_of(color_r, ch_r);
  assign step_val   = cur_chan[pif_pkg::CH_BITS-1] ? (pif_pkg::STEP_W'(0) - {1'b0, quo_r})
                                                   : {1'b0, quo_r};

  assign lvl = level_r[ent_r][ch_r];
  assign stp = step_r[ent_r][ch_r];
  assign sum = night_r ? ({2'b00, lvl} + {stp[pif_pkg::STEP_W-1], stp})
                       : ({2'b00, lvl} - {stp[pif_pkg::STEP_W-1], stp});

  always_comb begin
    if (sum[pif_pkg::SUM_W-1]) begin
      sat = '0;
    end else if (sum > pif_pkg::SUM_W'(pif_pkg::LEVEL_MAX)) begin
      sat = pif_pkg::LEVEL_W'(pif_pkg::LEVEL_MAX);
    end else begin
      sat = sum[pif_pkg::LEVEL_W-1:0];
    end
  end

  always_comb begin
    if (!snap_r) begin
      emit_color = col_r;
    end else if (night_r) begin
      emit_color = base_r[ent_r] ^ pif_pkg::COLOR_MASK;
    end else begin
      emit_color = base_r[ent_r];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pif_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.req_type == pif_pkg::REQ_TICK) begin
            state_nxt = in_data.invert_over ? pif_pkg::ST_EMIT : pif_pkg::ST_CALC;
          end else if (load_ok) begin
            state_nxt = pif_pkg::ST_DIV;
          end
        end
      end
      pif_pkg::ST_DIV: begin
        if (div_last) begin
          state_nxt = pif_pkg::ST_DIV_STORE;
        end
      end
      pif_pkg::ST_DIV_STORE: begin
        state_nxt = ch_last ? pif_pkg::ST_IDLE : pif_pkg::ST_DIV;
      end
      pif_pkg::ST_CALC: begin
        if (ch_last) begin
          state_nxt = pif_pkg::ST_EMIT;
        end
      end
      pif_pkg::ST_EMIT: begin
        if (emit_go) begin
          if (ent_last) begin
            state_nxt = pif_pkg::ST_IDLE;
          end else begin
            state_nxt = snap_r ? pif_pkg::ST_EMIT : pif_pkg::ST_CALC;
          end
        end
      end
      default: state_nxt = pif_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_c = 1'b1;
    emit_go    = 1'b0;
    unique case (state_r)
      pif_pkg::ST_IDLE: in_stall_c = 1'b0;
      pif_pkg::ST_EMIT: emit_go    = !out_valid_r || !out_stall;
      default: begin
        in_stall_c = 1'b1;
        emit_go    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pif_pkg::ST_IDLE;
      frames_r    <= pif_pkg::FRAMES_W'(pif_pkg::FRAMES_RESET);
      out_valid_r <= 1'b0;
      ent_r       <= '0;
      ch_r        <= '0;
      cnt_r       <= '0;
      for (int e = 0; e < pif_pkg::NUM_ENTRIES; e++) begin
        base_r[e] <= '0;
        for (int c = 0; c < pif_pkg::NUM_CH; c++) begin
          level_r[e][c] <= '0;
          step_r[e][c]  <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        frames_r <= cfg_data;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        pif_pkg::ST_IDLE: begin
          ent_r <= '0;
          ch_r  <= '0;
          cnt_r <= '0;
          if (in_acc && in_data.req_type == pif_pkg::REQ_LOAD && load_ok) begin
            base_r[pif_pkg::IDX_W'(in_data.entry_index - pif_pkg::ENT_W'(1))] <=
              in_data.base_color;
            for (int c = 0; c < pif_pkg::NUM_CH; c++) begin
              level_r[pif_pkg::IDX_W'(in_data.entry_index - pif_pkg::ENT_W'(1))][c] <=
                {chan_of(in_data.base_color, pif_pkg::CH_W'(c)), pif_pkg::FRAC_BITS'(0)};
            end
          end
        end
        pif_pkg::ST_DIV: begin
          cnt_r <= cnt_r + pif_pkg::CNT_W'(1);
        end
        pif_pkg::ST_DIV_STORE: begin
          step_r[lidx_r][ch_r] <= step_val;
          ch_r  <= ch_r + pif_pkg::CH_W'(1);
          cnt_r <= '0;
        end
        pif_pkg::ST_CALC: begin
          level_r[ent_r][ch_r] <= sat;
          ch_r <= ch_r + pif_pkg::CH_W'(1);
        end
        pif_pkg::ST_EMIT: begin
          if (emit_go) begin
            ent_r <= ent_r + pif_pkg::IDX_W'(1);
            ch_r  <= '0;
          end
        end
        default: begin
          ch_r <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      pif_pkg::ST_IDLE: begin
        if (in_acc) begin
          lidx_r  <= pif_pkg::IDX_W'(in_data.entry_index - pif_pkg::ENT_W'(1));
          color_r <= in_data.base_color;
          night_r <= in_data.night;
          snap_r  <= in_data.invert_over;
          rem_r   <= '0;
          quo_r   <= num_of(chan_of(in_data.base_color, '0));
        end
      end
      pif_pkg::ST_DIV: begin
        rem_r <= rem_next;
        quo_r <= {quo_r[pif_pkg::LEVEL_W-2:0], div_ge};
      end
      pif_pkg::ST_DIV_STORE: begin
        rem_r <= '0;
        quo_r <= num_of(chan_of(color_r, ch_r + pif_pkg::CH_W'(1)));
      end
      pif_pkg::ST_CALC: begin
        case (ch_r)
          2'd0:    col_r[pif_pkg::CH_BITS-1:0] <= sat[pif_pkg::LEVEL_W-1:pif_pkg::FRAC_BITS];
          2'd1:    col_r[2*pif_pkg::CH_BITS-1:pif_pkg::CH_BITS] <=
                     sat[pif_pkg::LEVEL_W-1:pif_pkg::FRAC_BITS];
          default: col_r[3*pif_pkg::CH_BITS-1:2*pif_pkg::CH_BITS] <=
                     sat[pif_pkg::LEVEL_W-1:pif_pkg::FRAC_BITS];
        endcase
      end
      pif_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_data_r.out_index <= pif_pkg::ENT_W'(ent_r) + pif_pkg::ENT_W'(1);
          out_data_r.color     <= emit_color;
          out_data_r.last      <= ent_last;
        end
      end
      default: begin
        rem_r <= rem_r;
      end
    endcase
  end

  assign in_stall  = in_stall_c;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

// ===== rtl/core/pif_checker.sv =====
// ----------------------------------------------------------------------------
// Palette inversion fader checker
// Port-level assertions on the fader, attached to the fader module by bind.
// ----------------------------------------------------------------------------
module pif_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input pif_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input pif_pkg::out_item_t out_data
);

  // A stalled result item holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  // No input item is taken while a tick's run is still being delivered.
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("input taken during a tick run");

  // A tick keeps the block busy on the following cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.req_type == pif_pkg::REQ_TICK |=> in_stall)
    else $error("block idle straight after a tick");

  // Result items carry entry numbers within the palette.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_index >= pif_pkg::ENT_W'(1) &&
                  out_data.out_index <= pif_pkg::ENT_W'(pif_pkg::NUM_ENTRIES))
    else $error("result entry number out of range");

endmodule

bind palette_inversion_fader pif_checker u_pif_checker (.*);
